>>> src/hcbd_pkg.sv
package hcbd_pkg;

    localparam int MAX_SYMBOLS  = 16;
    localparam int MAX_CODE_LEN = 15;
    localparam int NODE_CNT     = 2 * MAX_SYMBOLS - 1;

    localparam int SYM_W   = 8;
    localparam int FREQ_W  = 24;
    localparam int WGT_W   = 28;
    localparam int NODE_W  = 5;
    localparam int LEAF_W  = 4;
    localparam int CNT_W   = 5;
    localparam int CODE_W  = 15;
    localparam int LEN_W   = 4;

    localparam logic [NODE_W-1:0] NO_PARENT = 5'd31;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    localparam logic [1:0] KIND_CODE  = 2'd0;
    localparam logic [1:0] KIND_SYM   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [SYM_W-1:0] ERR_OVERFLOW   = 8'd1;
    localparam logic [SYM_W-1:0] ERR_NOT_BUILT  = 8'd2;
    localparam logic [SYM_W-1:0] ERR_NO_MATCH   = 8'd3;
    localparam logic [SYM_W-1:0] ERR_EMPTY      = 8'd4;
    localparam logic [SYM_W-1:0] ERR_TOO_LONG   = 8'd5;

    typedef struct packed {
        logic accept;
        logic loop;
        logic scan_a;
        logic scan_b;
        logic merge;
        logic walk;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic merges_done;
        logic scan_end;
        logic walk_root;
        logic walk_last_leaf;
        logic walk_over;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

>>> src/huffman_code_builder_decoder_unit.sv
// Huffman table builder and bit-serial decoder. A load word (tuser 0) stores one
// symbol and its count, or returns an overflow error when the table is full; a
// decode word (tuser 2) takes one bit and is matched against every loaded table
// entry in the same cycle. A build word (tuser 1) runs n-1 merges over the n
// loaded leaves; each merge scans the live nodes twice through one shared
// compare unit, then the tree is walked from each leaf to the root, and the n
// code words leave one per cycle as the output register drains. No new word is
// taken until a build has delivered its last result word.
module huffman_code_builder_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // symbol, frequency, bit_req
    input  logic [1:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // out_symbol, code_bits, code_length
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast
);
    import hcbd_pkg::*;

    cmd_t    cmd;
    status_t sts;

    hcbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hcbd_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> src/hcbd_ctrl.sv
module hcbd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [1:0]       s_tuser,
    output logic             s_tready,
    input  hcbd_pkg::status_t sts,
    output hcbd_pkg::cmd_t   cmd
);
    import hcbd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOP   = 3'd1;
    localparam logic [2:0] ST_SCAN_A = 3'd2;
    localparam logic [2:0] ST_SCAN_B = 3'd3;
    localparam logic [2:0] ST_MERGE  = 3'd4;
    localparam logic [2:0] ST_WALK   = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    if (s_tuser == CMD_BUILD && !sts.n_zero) begin
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_LOOP: begin
                cmd.loop   = 1'b1;
                state_next = sts.merges_done ? ST_WALK : ST_SCAN_A;
            end
            ST_SCAN_A: begin
                cmd.scan_a = 1'b1;
                if (sts.scan_end) begin
                    state_next = ST_SCAN_B;
                end
            end
            ST_SCAN_B: begin
                cmd.scan_b = 1'b1;
                if (sts.scan_end) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                cmd.merge  = 1'b1;
                state_next = ST_LOOP;
            end
            ST_WALK: begin
                if (sts.walk_over) begin
                    if (sts.out_free) begin
                        cmd.walk   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.walk = 1'b1;
                    if (sts.walk_root && sts.walk_last_leaf) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/hcbd_datapath.sv
module hcbd_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [39:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  hcbd_pkg::cmd_t    cmd,
    output hcbd_pkg::status_t sts
);
    import hcbd_pkg::*;

    logic [SYM_W-1:0]  leaf_sym_reg  [MAX_SYMBOLS];
    logic [WGT_W-1:0]  weight_reg    [NODE_CNT];
    logic [CNT_W-1:0]  lcount_reg    [NODE_CNT];
    logic [NODE_W-1:0] parent_reg    [NODE_CNT];
    logic              side_reg      [NODE_CNT];
    logic [NODE_CNT-1:0] alive_reg;
    logic [CODE_W-1:0] tcode_reg     [MAX_SYMBOLS];
    logic [LEN_W-1:0]  tlen_reg      [MAX_SYMBOLS];

    logic [CNT_W-1:0]  loaded_reg;
    logic              ready_reg;
    logic [CODE_W-1:0] pend_bits_reg;
    logic [LEN_W-1:0]  pend_len_reg;

    logic [NODE_W-1:0] total_reg;
    logic [NODE_W-1:0] idx_reg;
    logic              best_v_reg;
    logic [NODE_W-1:0] best_reg;
    logic [WGT_W-1:0]  best_w_reg;
    logic [NODE_W-1:0] a_reg;
    logic [WGT_W-1:0]  a_w_reg;
    logic [CNT_W-1:0]  a_c_reg;
    logic [NODE_W-1:0] b_reg;
    logic [WGT_W-1:0]  b_w_reg;
    logic [CNT_W-1:0]  b_c_reg;
    logic [LEAF_W-1:0] leaf_reg;
    logic [NODE_W-1:0] node_reg;
    logic [LEN_W-1:0]  wlen_reg;
    logic [CODE_W-1:0] wcode_reg;

    logic              out_v_reg;
    logic [1:0]        out_kind_reg;
    logic [SYM_W-1:0]  out_sym_reg;
    logic [CODE_W-1:0] out_bits_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_last_reg;

    logic [1:0]        in_cmd;
    logic [SYM_W-1:0]  in_sym;
    logic [FREQ_W-1:0] in_freq;
    logic              in_bit;

    assign in_cmd  = s_tuser;
    assign in_sym  = s_tdata[7:0];
    assign in_freq = s_tdata[31:8];
    assign in_bit  = s_tdata[32];

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_len_reg, out_bits_reg, out_sym_reg};

    logic              take_idx;
    logic [NODE_W-1:0] chosen;
    logic [WGT_W-1:0]  chosen_w;
    logic [NODE_W-1:0] par;
    logic [CNT_W-1:0]  load_slot;
    logic [CNT_W-1:0]  n_minus1;
    logic [CNT_W:0]    node_goal;
    logic [CODE_W-1:0] dec_bits;
    logic [LEN_W-1:0]  dec_len;
    logic              dec_hit;
    logic [LEAF_W-1:0] dec_idx;
    logic              swap;

    assign take_idx = alive_reg[idx_reg] && (!best_v_reg || weight_reg[idx_reg] < best_w_reg);
    assign chosen   = take_idx ? idx_reg : best_reg;
    assign chosen_w = take_idx ? weight_reg[idx_reg] : best_w_reg;
    assign par      = parent_reg[node_reg];
    assign load_slot = ready_reg ? '0 : loaded_reg;
    assign n_minus1  = loaded_reg - 1'b1;
    assign node_goal = {loaded_reg, 1'b0} - 1'b1;
    assign dec_bits  = {pend_bits_reg[CODE_W-2:0], in_bit};
    assign dec_len   = pend_len_reg + 1'b1;
    assign swap      = (a_w_reg == b_w_reg) && (a_c_reg == b_c_reg);

    always_comb begin
        dec_hit = 1'b0;
        dec_idx = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (CNT_W'(i) < loaded_reg && tlen_reg[i] == dec_len && tcode_reg[i] == dec_bits) begin
                dec_hit = 1'b1;
                dec_idx = LEAF_W'(i);
            end
        end
    end

    always_comb begin
        sts.n_zero         = (loaded_reg == '0);
        sts.merges_done    = ({1'b0, total_reg} == node_goal);
        sts.scan_end       = (idx_reg == total_reg - 1'b1);
        sts.walk_root      = (par == NO_PARENT);
        sts.walk_last_leaf = ({1'b0, leaf_reg} == n_minus1);
        sts.walk_over      = (par != NO_PARENT) && (wlen_reg >= LEN_W'(MAX_CODE_LEN));
        sts.emit_last      = ({1'b0, leaf_reg} == n_minus1);
        sts.out_free       = !out_v_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg     <= '0;
            loaded_reg    <= '0;
            ready_reg     <= 1'b0;
            pend_bits_reg <= '0;
            pend_len_reg  <= '0;
            out_v_reg     <= 1'b0;
        end else begin
            if (m_tready) begin
                out_v_reg <= 1'b0;
            end
            if (cmd.accept) begin
                case (in_cmd)
                    CMD_LOAD: begin
                        if (ready_reg) begin
                            ready_reg     <= 1'b0;
                            pend_bits_reg <= '0;
                            pend_len_reg  <= '0;
                        end
                        if (load_slot >= CNT_W'(MAX_SYMBOLS)) begin
                            loaded_reg   <= load_slot;
                            out_v_reg    <= 1'b1;
                            out_kind_reg <= KIND_ERROR;
                            out_sym_reg  <= ERR_OVERFLOW;
                            out_bits_reg <= '0;
                            out_len_reg  <= '0;
                            out_last_reg <= 1'b1;
                        end else begin
                            leaf_sym_reg[load_slot[LEAF_W-1:0]] <= in_sym;
                            weight_reg[load_slot[LEAF_W-1:0]]   <= WGT_W'(in_freq);
                            loaded_reg <= load_slot + 1'b1;
                        end
                    end
                    CMD_BUILD: begin
                        if (loaded_reg == '0) begin
                            out_v_reg    <= 1'b1;
                            out_kind_reg <= KIND_ERROR;
                            out_sym_reg  <= ERR_EMPTY;
                            out_bits_reg <= '0;
                            out_len_reg  <= '0;
                            out_last_reg <= 1'b1;
                        end else begin
                            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                                if (CNT_W'(i) < loaded_reg) begin
                                    lcount_reg[i] <= CNT_W'(1);
                                    alive_reg[i]  <= 1'b1;
                                    parent_reg[i] <= NO_PARENT;
                                    side_reg[i]   <= 1'b0;
                                end
                            end
                            total_reg <= loaded_reg;
                        end
                    end
                    CMD_DECODE: begin
                        out_bits_reg <= '0;
                        out_len_reg  <= '0;
                        out_last_reg <= 1'b1;
                        if (!ready_reg) begin
                            out_v_reg    <= 1'b1;
                            out_kind_reg <= KIND_ERROR;
                            out_sym_reg  <= ERR_NOT_BUILT;
                        end else if (dec_hit) begin
                            out_v_reg     <= 1'b1;
                            out_kind_reg  <= KIND_SYM;
                            out_sym_reg   <= leaf_sym_reg[dec_idx];
                            out_bits_reg  <= dec_bits;
                            out_len_reg   <= dec_len;
                            pend_bits_reg <= '0;
                            pend_len_reg  <= '0;
                        end else if (dec_len >= LEN_W'(MAX_CODE_LEN)) begin
                            out_v_reg     <= 1'b1;
                            out_kind_reg  <= KIND_ERROR;
                            out_sym_reg   <= ERR_NO_MATCH;
                            pend_bits_reg <= '0;
                            pend_len_reg  <= '0;
                        end else begin
                            pend_bits_reg <= dec_bits;
                            pend_len_reg  <= dec_len;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.loop) begin
                idx_reg    <= '0;
                best_v_reg <= 1'b0;
                leaf_reg   <= '0;
                node_reg   <= '0;
                wlen_reg   <= '0;
                wcode_reg  <= '0;
            end
            if (cmd.scan_a || cmd.scan_b) begin
                if (take_idx) begin
                    best_v_reg <= 1'b1;
                    best_reg   <= idx_reg;
                    best_w_reg <= weight_reg[idx_reg];
                end
                idx_reg <= idx_reg + 1'b1;
                if (sts.scan_end) begin
                    idx_reg           <= '0;
                    best_v_reg        <= 1'b0;
                    alive_reg[chosen] <= 1'b0;
                    if (cmd.scan_a) begin
                        a_reg   <= chosen;
                        a_w_reg <= chosen_w;
                        a_c_reg <= lcount_reg[chosen];
                    end else begin
                        b_reg   <= chosen;
                        b_w_reg <= chosen_w;
                        b_c_reg <= lcount_reg[chosen];
                    end
                end
            end
            if (cmd.merge) begin
                weight_reg[total_reg] <= a_w_reg + b_w_reg;
                lcount_reg[total_reg] <= a_c_reg + b_c_reg;
                parent_reg[a_reg]     <= total_reg;
                parent_reg[b_reg]     <= total_reg;
                side_reg[a_reg]       <= swap;
                side_reg[b_reg]       <= !swap;
                parent_reg[total_reg] <= NO_PARENT;
                side_reg[total_reg]   <= 1'b0;
                alive_reg[total_reg]  <= 1'b1;
                total_reg             <= total_reg + 1'b1;
            end
            if (cmd.walk) begin
                if (sts.walk_root) begin
                    tcode_reg[leaf_reg] <= wcode_reg;
                    tlen_reg[leaf_reg]  <= wlen_reg;
                    wlen_reg  <= '0;
                    wcode_reg <= '0;
                    if (sts.walk_last_leaf) begin
                        leaf_reg      <= '0;
                        pend_bits_reg <= '0;
                        pend_len_reg  <= '0;
                    end else begin
                        leaf_reg <= leaf_reg + 1'b1;
                        node_reg <= NODE_W'(leaf_reg) + 1'b1;
                    end
                end else if (sts.walk_over) begin
                    ready_reg    <= 1'b0;
                    out_v_reg    <= 1'b1;
                    out_kind_reg <= KIND_ERROR;
                    out_sym_reg  <= ERR_TOO_LONG;
                    out_bits_reg <= '0;
                    out_len_reg  <= '0;
                    out_last_reg <= 1'b1;
                end else begin
                    wcode_reg <= wcode_reg | (CODE_W'(side_reg[node_reg]) << wlen_reg);
                    wlen_reg  <= wlen_reg + 1'b1;
                    node_reg  <= par;
                end
            end
            if (cmd.emit) begin
                out_v_reg    <= 1'b1;
                out_kind_reg <= KIND_CODE;
                out_sym_reg  <= leaf_sym_reg[leaf_reg];
                out_bits_reg <= tcode_reg[leaf_reg];
                out_len_reg  <= tlen_reg[leaf_reg];
                out_last_reg <= sts.emit_last;
                leaf_reg     <= leaf_reg + 1'b1;
                if (sts.emit_last) begin
                    ready_reg <= 1'b1;
                end
            end
        end
    end

endmodule
